// File: design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg: shared types for the sorted list deque
// Command and status codes, item structs and the control word that the top
// level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_POP_LARGE = 2'd1,
        CMD_POP_SMALL = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                        cmd;
        logic signed [VALUE_W-1:0]   value_in;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   removed_value;
        logic signed [VALUE_W-1:0]   largest;
        logic signed [VALUE_W-1:0]   smallest;
        logic        [COUNT_W-1:0]   count;
        status_t                     status;
    } result_t;

    // Operations that passed their full/empty checks; at most one is set.
    typedef struct packed {
        logic insert;
        logic pop_front;
        logic pop_back;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: design/sld_cell.sv
// ----------------------------------------------------------------------------
// sld_cell: one slot of the sorted chain
// Holds one value and its valid bit. On insert it keeps, takes the new value
// or takes its left neighbor's value; on a front removal it takes its right
// neighbor's value.
// ----------------------------------------------------------------------------
module sld_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sld_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [sld_pkg::VALUE_W-1:0]  value_in,
    input  logic signed [sld_pkg::VALUE_W-1:0]  left_value,
    input  logic                                left_valid,
    input  logic                                left_take,
    input  logic signed [sld_pkg::VALUE_W-1:0]  right_value,
    input  logic                                right_valid,
    output logic signed [sld_pkg::VALUE_W-1:0]  value,
    output logic                                valid,
    output logic                                take,
    output logic signed [sld_pkg::VALUE_W-1:0]  tail_value
);

    logic signed [sld_pkg::VALUE_W-1:0] value_reg;
    logic signed [sld_pkg::VALUE_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;

    // The new value lands at or before this cell. Monotone along the chain
    // because the contents are sorted in descending order.
    assign take = !valid_reg || (value_reg <= value_in);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (take)
            begin
                value_next = left_take ? left_value : value_in;
            end
            valid_next = valid_reg | left_valid;
        end
        else if (ctrl.pop_front)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.pop_back)
        begin
            valid_next = valid_reg & right_valid;
        end
        else if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value      = value_reg;
    assign valid      = valid_reg;
    assign tail_value = (valid_reg && !right_valid) ? value_reg : '0;

endmodule

// File: design/sorted_list_deque.sv
// ----------------------------------------------------------------------------
// sorted_list_deque: bounded double-ended priority store
// A chain of CAPACITY cells keeps signed values in descending order.
// ----------------------------------------------------------------------------
// An item is accepted on any cycle in which start is high; busy never rises,
// so one item can be taken every clock cycle. Each item updates the whole
// cell chain at the edge that accepts it, since every cell decides locally
// from its own compare and its neighbors. Its result is driven with done from
// the first edge after acceptance and stays for that one cycle only, so the
// receiver must capture it at the second edge after acceptance. The store
// needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_list_deque #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sld_pkg::request_t    request,
    output logic                 done,
    output sld_pkg::result_t     result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [sld_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic                               cell_valid [CAPACITY];
    logic                               cell_take  [CAPACITY];
    logic signed [sld_pkg::VALUE_W-1:0] cell_tail  [CAPACITY];

    logic signed [sld_pkg::VALUE_W-1:0] tail_value;
    logic                               accept;
    logic                               is_empty;
    logic                               is_full;
    sld_pkg::cell_ctrl_t                ctrl;

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W+4:0]                   count_ext;

    logic                               acc_reg;
    logic                               done_reg;
    logic signed [sld_pkg::VALUE_W-1:0] removed_reg;
    logic signed [sld_pkg::VALUE_W-1:0] removed_next;
    sld_pkg::status_t                   status_reg;
    sld_pkg::status_t                   status_next;
    sld_pkg::result_t                   result_reg;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_empty = !cell_valid[0];
    assign is_full  = (count_reg == CNT_W'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [sld_pkg::VALUE_W-1:0] lv;
            logic                               lval;
            logic                               ltake;
            logic signed [sld_pkg::VALUE_W-1:0] rv;
            logic                               rval;

            if (g == 0)
            begin : g_first
                assign lv    = '0;
                assign lval  = 1'b1;
                assign ltake = 1'b0;
            end
            else
            begin : g_mid_l
                assign lv    = cell_value[g-1];
                assign lval  = cell_valid[g-1];
                assign ltake = cell_take[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rv   = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv   = cell_value[g+1];
                assign rval = cell_valid[g+1];
            end

            sld_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .value_in    (request.value_in),
                .left_value  (lv),
                .left_valid  (lval),
                .left_take   (ltake),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[g]),
                .valid       (cell_valid[g]),
                .take        (cell_take[g]),
                .tail_value  (cell_tail[g])
            );
        end
    endgenerate

    // At most one cell marks itself as the last valid one; the rest give zero.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    always_comb
    begin
        ctrl         = '0;
        count_next   = count_reg;
        removed_next = '0;
        status_next  = sld_pkg::ST_OK;
        if (accept)
        begin
            case (request.cmd)
                sld_pkg::CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = sld_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                sld_pkg::CMD_POP_LARGE:
                begin
                    if (is_empty)
                    begin
                        status_next = sld_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_front = 1'b1;
                        count_next     = count_reg - CNT_W'(1);
                        removed_next   = cell_value[0];
                    end
                end
                sld_pkg::CMD_POP_SMALL:
                begin
                    if (is_empty)
                    begin
                        status_next = sld_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_back = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        removed_next  = tail_value;
                    end
                end
                sld_pkg::CMD_CLEAR:
                begin
                    ctrl.clear = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            acc_reg   <= accept;
            done_reg  <= acc_reg;
        end
    end

    assign count_ext = {5'b0, count_reg};

    // The second stage reads the chain after the first stage's update.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
        end
        if (acc_reg)
        begin
            result_reg.removed_value <= removed_reg;
            result_reg.largest       <= is_empty ? '0 : cell_value[0];
            result_reg.smallest      <= tail_value;
            result_reg.count         <= count_ext[4:0];
            result_reg.status        <= status_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
